// File: hw/rtl/ordered_array_list_defines.svh
// Assertion macros shared by the list RTL.
// Each macro samples on i_clk and is held off while i_rst_n is low.
`ifndef ORDERED_ARRAY_LIST_DEFINES_SVH
`define ORDERED_ARRAY_LIST_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define OAL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("ordered_array_list check failed");

// Check a consequent in the cycle after its antecedent.
`define OAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("ordered_array_list check failed");

`endif

// File: hw/rtl/oal_pkg.sv
package oal_pkg;

    // Number of entry cells in the chain
    localparam int CAPACITY = 16;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int IDX_W  = $clog2(CAPACITY);

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic [DATA_W-1:0] t_entry;

    // Per-cell control for one accepted word
    typedef struct packed {
        logic load_val;
        logic take_left;
        logic take_right;
        logic cmp_en;
        logic live;
    } t_cell_ctl;

endpackage

// File: hw/rtl/ordered_array_list.sv
// Accepted request words pass through stage 1 and then the output register.
// Throughput: one request word per cycle while o_stall is low; each entry cell
// shifts or compares on acceptance; the lowest-match encode feeds the output.
// Reset (i_rst_n low, synchronous) empties the list and both pipeline stages.
// Entry contents are not cleared; only entries below the count are ever read.
module ordered_array_list (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [oal_pkg::FUNC_W-1:0]        i_func,
    input  logic [oal_pkg::CNT_W-1:0]         i_position,
    input  logic signed [oal_pkg::DATA_W-1:0] i_item_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [oal_pkg::STAT_W-1:0]        o_status,
    output logic [oal_pkg::CNT_W-1:0]         o_found_position,
    output logic signed [oal_pkg::DATA_W-1:0] o_removed_value,
    output logic [oal_pkg::CNT_W-1:0]         o_list_length
);

`include "ordered_array_list_defines.svh"

    localparam int CW = oal_pkg::CNT_W;

    // Handshake and pipeline control
    logic w_ld1;
    logic w_adv2;
    logic w_accept;

    logic r_s1_valid;
    logic r_o_valid;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Stage 1 payload
    logic [oal_pkg::STAT_W-1:0] r_s1_status;
    logic [oal_pkg::STAT_W-1:0] n_s1_status;
    oal_pkg::t_entry            r_s1_removed;
    oal_pkg::t_entry            n_s1_removed;
    logic                       r_s1_locate;

    // Output payload
    logic [oal_pkg::STAT_W-1:0] r_o_status;
    logic [CW-1:0]              r_o_found;
    oal_pkg::t_entry            r_o_removed;
    logic [CW-1:0]              r_o_length;

    // Request decode
    logic [CW:0]              w_pos_x;
    logic [CW:0]              w_cnt_x;
    logic                     w_is_ins;
    logic                     w_is_del;
    logic                     w_ins_range;
    logic                     w_del_range;
    logic                     w_full;
    logic                     w_ins_ok;
    logic                     w_del_ok;
    logic [oal_pkg::IDX_W-1:0] w_del_idx;

    oal_pkg::t_entry            w_entry [oal_pkg::CAPACITY];
    logic [oal_pkg::CAPACITY-1:0] w_match;

    function automatic logic [CW-1:0] lowest_match(
        input logic [oal_pkg::CAPACITY-1:0] m
    );
        logic [CW-1:0] f;
        f = '0;
        for (int k = oal_pkg::CAPACITY - 1; k >= 0; k--) begin
            if (m[k]) begin
                f = CW'(k + 1);
            end
        end
        return f;
    endfunction

    // Stage 1 loads when empty or when the output slot frees up
    assign w_adv2   = !r_o_valid || !i_stall;
    assign w_ld1    = !r_s1_valid || w_adv2;
    assign o_stall  = !w_ld1;
    assign w_accept = i_valid && w_ld1;

    // Decode position checks against the current count
    assign w_pos_x     = {1'b0, i_position};
    assign w_cnt_x     = {1'b0, r_count};
    assign w_is_ins    = (i_func == oal_pkg::FUNC_INSERT);
    assign w_is_del    = (i_func == oal_pkg::FUNC_DELETE);
    assign w_ins_range = (i_position != '0) && (w_pos_x <= w_cnt_x + (CW + 1)'(1));
    assign w_del_range = (i_position != '0) && (w_pos_x <= w_cnt_x);
    assign w_full      = (r_count >= CW'(oal_pkg::CAPACITY));
    assign w_ins_ok    = w_is_ins && w_ins_range && !w_full;
    assign w_del_ok    = w_is_del && w_del_range;
    assign w_del_idx   = oal_pkg::IDX_W'(i_position - CW'(1));

    // Chain of entry cells
    for (genvar k = 0; k < oal_pkg::CAPACITY; k++) begin : g_cell
        localparam logic [CW:0] KX = (CW + 1)'(k);
        localparam logic [CW:0] K1 = (CW + 1)'(k + 1);

        oal_pkg::t_cell_ctl w_ctl;
        oal_pkg::t_entry    w_left;
        oal_pkg::t_entry    w_right;

        assign w_ctl.load_val   = w_accept && w_ins_ok && (w_pos_x == K1);
        assign w_ctl.take_left  = w_accept && w_ins_ok && (w_pos_x <= KX);
        assign w_ctl.take_right = w_accept && w_del_ok && (w_pos_x <= K1);
        assign w_ctl.cmp_en     = w_accept;
        assign w_ctl.live       = (w_cnt_x > KX);

        if (k == 0) begin : g_first
            assign w_left = w_entry[k];
        end else begin : g_inner_l
            assign w_left = w_entry[k-1];
        end

        if (k == oal_pkg::CAPACITY - 1) begin : g_last
            assign w_right = w_entry[k];
        end else begin : g_inner_r
            assign w_right = w_entry[k+1];
        end

        oal_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (oal_pkg::t_entry'(i_item_value)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[k]),
            .o_match (w_match[k])
        );
    end

    // Work out status, removed word and new count
    always_comb begin
        n_s1_status  = oal_pkg::ST_DONE;
        n_s1_removed = '0;
        n_count      = r_count;
        priority if (w_is_ins) begin
            if (!w_ins_range) begin
                n_s1_status = oal_pkg::ST_RANGE;
            end else if (w_full) begin
                n_s1_status = oal_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (w_is_del) begin
            if (!w_del_range) begin
                n_s1_status = oal_pkg::ST_RANGE;
            end else begin
                n_s1_removed = w_entry[w_del_idx];
                n_count      = r_count - CW'(1);
            end
        end else begin
            // Locate and the spare code leave the list as it is
            n_count = r_count;
        end
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_ld1) begin
                r_s1_valid <= i_valid;
            end
            if (w_adv2) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // Hold stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_status  <= n_s1_status;
            r_s1_removed <= n_s1_removed;
            r_s1_locate  <= (i_func == oal_pkg::FUNC_LOCATE);
        end
    end

    // Encode the lowest match and load the output word
    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_s1_valid) begin
            r_o_status  <= r_s1_status;
            r_o_found   <= r_s1_locate ? lowest_match(w_match) : '0;
            r_o_removed <= r_s1_removed;
            r_o_length  <= r_count;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_found;
    assign o_removed_value  = r_o_removed;
    assign o_list_length    = r_o_length;

    // Stage 1 always sees the count its own request left behind, since no
    // later word can be accepted until it moves on; keep it in range
    `OAL_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(oal_pkg::CAPACITY))
    `OAL_ASSERT_NEXT(a_insert_grows, w_accept && w_ins_ok,
        r_count == $past(r_count) + CW'(1))
    `OAL_ASSERT_SAME(a_full_len, r_o_valid && (r_o_status == oal_pkg::ST_FULL),
        r_o_length == CW'(oal_pkg::CAPACITY))
    `OAL_ASSERT_SAME(a_found_len, r_o_valid && (r_o_found != '0),
        (r_o_found <= r_o_length) && (r_o_status == oal_pkg::ST_DONE))
    `OAL_ASSERT_SAME(a_removed_done, r_o_valid && (r_o_removed != '0),
        r_o_status == oal_pkg::ST_DONE)

endmodule

// File: hw/rtl/oal_cell.sv
module oal_cell (
    input  logic               i_clk,
    input  oal_pkg::t_cell_ctl i_ctl,
    input  oal_pkg::t_entry    i_value,
    input  oal_pkg::t_entry    i_left,
    input  oal_pkg::t_entry    i_right,
    output oal_pkg::t_entry    o_entry,
    output logic               o_match
);

    oal_pkg::t_entry r_entry;
    logic            r_match;

    // Load the new value, shift from a neighbor, or hold
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_val) begin
            r_entry <= i_value;
        end else if (i_ctl.take_left) begin
            r_entry <= i_left;
        end else if (i_ctl.take_right) begin
            r_entry <= i_right;
        end
    end

    // Capture the compare against the searched value for a live entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_match <= i_ctl.live && (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// File: sim/ordered_array_list_tb.sv
module ordered_array_list_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 4;
    localparam int DIR_ROWS     = 25;
    localparam int RAND_WORDS   = 1000;
    localparam int IDLE_PCT     = 27;
    localparam int CALM_FIRST   = 500;
    localparam int CALM_LAST    = 700;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 100000;

    // Spare operation code, answered without touching the list
    localparam logic [oal_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // Random traffic moods
    localparam int MOOD_GROW   = 0;
    localparam int MOOD_SHRINK = 1;
    localparam int MOOD_MIX    = 2;

    typedef struct packed {
        logic [oal_pkg::STAT_W-1:0]        status;
        logic [oal_pkg::CNT_W-1:0]         found;
        logic signed [oal_pkg::DATA_W-1:0] removed;
        logic [oal_pkg::CNT_W-1:0]         length;
    } t_list_result;

    typedef struct packed {
        logic [oal_pkg::FUNC_W-1:0]        func;
        logic [oal_pkg::CNT_W-1:0]         pos;
        logic signed [oal_pkg::DATA_W-1:0] val;
        logic                              typed;
        t_list_result                      want;
    } t_req_word;

    typedef struct packed {
        t_req_word  word;
        logic [4:0] rep;
    } t_dir_row;

    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_valid      = 1'b0;
    logic                              o_stall;
    logic [oal_pkg::FUNC_W-1:0]        i_func       = '0;
    logic [oal_pkg::CNT_W-1:0]         i_position   = '0;
    logic signed [oal_pkg::DATA_W-1:0] i_item_value = '0;
    logic                              o_valid;
    logic                              i_stall      = 1'b0;
    logic [oal_pkg::STAT_W-1:0]        o_status;
    logic [oal_pkg::CNT_W-1:0]         o_found_position;
    logic signed [oal_pkg::DATA_W-1:0] o_removed_value;
    logic [oal_pkg::CNT_W-1:0]         o_list_length;

    ordered_array_list dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_removed_value  (o_removed_value),
        .o_list_length    (o_list_length)
    );

    // Shadow copy of the list
    oal_pkg::t_entry list_entries [oal_pkg::CAPACITY];
    int              list_count = 0;

    t_list_result awaited_results [$];
    t_dir_row     dir_table [DIR_ROWS];
    t_req_word    cur_word;

    int   dir_idx        = 0;
    int   dir_rep        = 0;
    int   rand_issued    = 0;
    int   mood           = MOOD_MIX;
    int   mood_left      = 0;
    int   words_accepted = 0;
    int   results_seen   = 0;
    int   error_count    = 0;
    int   cycle_count    = 0;
    logic requests_done  = 1'b0;
    logic calm_window;

    assign calm_window = (words_accepted >= CALM_FIRST) && (words_accepted < CALM_LAST);

    // Toggle the clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Apply one request to the shadow list and return what it answers
    function automatic t_list_result list_apply(logic [oal_pkg::FUNC_W-1:0] func,
                                                logic [oal_pkg::CNT_W-1:0] pos,
                                                logic signed [oal_pkg::DATA_W-1:0] val);
        t_list_result r;
        int k;
        int p;
        r = '0;
        p = int'(pos);
        unique case (func)
            oal_pkg::FUNC_INSERT: begin
                if (p < 1 || p > list_count + 1) begin
                    r.status = oal_pkg::ST_RANGE;
                end else if (list_count >= oal_pkg::CAPACITY) begin
                    r.status = oal_pkg::ST_FULL;
                end else begin
                    for (k = list_count; k >= p; k--) begin
                        list_entries[k] = list_entries[k-1];
                    end
                    list_entries[p-1] = val;
                    list_count++;
                end
            end
            oal_pkg::FUNC_DELETE: begin
                if (p < 1 || p > list_count) begin
                    r.status = oal_pkg::ST_RANGE;
                end else begin
                    r.removed = list_entries[p-1];
                    for (k = p; k < list_count; k++) begin
                        list_entries[k-1] = list_entries[k];
                    end
                    list_count--;
                end
            end
            oal_pkg::FUNC_LOCATE: begin
                // Scan downward so the lowest match wins
                for (k = list_count - 1; k >= 0; k--) begin
                    if (list_entries[k] == val) begin
                        r.found = oal_pkg::CNT_W'(k + 1);
                    end
                end
            end
            default: begin
            end
        endcase
        r.length = oal_pkg::CNT_W'(list_count);
        return r;
    endfunction

    function automatic t_dir_row mk_row(logic [oal_pkg::FUNC_W-1:0] func,
                                        logic [oal_pkg::CNT_W-1:0] pos,
                                        logic [oal_pkg::DATA_W-1:0] val, int rep, logic typed,
                                        logic [oal_pkg::STAT_W-1:0] status, int length);
        t_dir_row row;
        row = '0;
        row.word.func        = func;
        row.word.pos         = pos;
        row.word.val         = val;
        row.word.typed       = typed;
        row.word.want.status = status;
        row.word.want.length = oal_pkg::CNT_W'(length);
        row.rep              = 5'(rep);
        return row;
    endfunction

    // Directed words: empty list, extremes, range and full errors, fill and drain
    initial begin : build_table
        dir_table[0]  = mk_row(oal_pkg::FUNC_LOCATE, 5'd0,  32'h0000_0000, 1, 1'b1,
                               oal_pkg::ST_DONE,  0);
        dir_table[1]  = mk_row(oal_pkg::FUNC_DELETE, 5'd1,  32'h0000_0000, 1, 1'b1,
                               oal_pkg::ST_RANGE, 0);
        dir_table[2]  = mk_row(oal_pkg::FUNC_INSERT, 5'd0,  32'h0000_0005, 1, 1'b1,
                               oal_pkg::ST_RANGE, 0);
        dir_table[3]  = mk_row(oal_pkg::FUNC_INSERT, 5'd2,  32'h0000_0005, 1, 1'b1,
                               oal_pkg::ST_RANGE, 0);
        dir_table[4]  = mk_row(oal_pkg::FUNC_INSERT, 5'd1,  32'h8000_0000, 1, 1'b1,
                               oal_pkg::ST_DONE,  1);
        dir_table[5]  = mk_row(oal_pkg::FUNC_INSERT, 5'd2,  32'h7FFF_FFFF, 1, 1'b1,
                               oal_pkg::ST_DONE,  2);
        dir_table[6]  = mk_row(oal_pkg::FUNC_INSERT, 5'd1,  32'hFFFF_FFFF, 1, 1'b1,
                               oal_pkg::ST_DONE,  3);
        dir_table[7]  = mk_row(oal_pkg::FUNC_LOCATE, 5'd0,  32'h7FFF_FFFF, 1, 1'b0,
                               oal_pkg::ST_DONE,  0);
        dir_table[8]  = mk_row(oal_pkg::FUNC_LOCATE, 5'd9,  32'h8000_0000, 1, 1'b0,
                               oal_pkg::ST_DONE,  0);
        dir_table[9]  = mk_row(FUNC_SPARE,           5'd31, 32'hFFFF_FFFF, 1, 1'b1,
                               oal_pkg::ST_DONE,  3);
        dir_table[10] = mk_row(oal_pkg::FUNC_INSERT, 5'd31, 32'h0000_0000, 1, 1'b1,
                               oal_pkg::ST_RANGE, 3);
        dir_table[11] = mk_row(oal_pkg::FUNC_DELETE, 5'd4,  32'h0000_0000, 1, 1'b1,
                               oal_pkg::ST_RANGE, 3);
        dir_table[12] = mk_row(oal_pkg::FUNC_DELETE, 5'd0,  32'h0000_0000, 1, 1'b1,
                               oal_pkg::ST_RANGE, 3);
        dir_table[13] = mk_row(oal_pkg::FUNC_DELETE, 5'd2,  32'h0000_0000, 1, 1'b0,
                               oal_pkg::ST_DONE,  0);
        dir_table[14] = mk_row(oal_pkg::FUNC_INSERT, 5'd3,  32'h0000_0055, 14, 1'b0,
                               oal_pkg::ST_DONE, 0);
        dir_table[15] = mk_row(oal_pkg::FUNC_INSERT, 5'd17, 32'h0000_0001, 1, 1'b1,
                               oal_pkg::ST_FULL,  16);
        dir_table[16] = mk_row(oal_pkg::FUNC_INSERT, 5'd1,  32'h0000_0001, 1, 1'b1,
                               oal_pkg::ST_FULL,  16);
        dir_table[17] = mk_row(oal_pkg::FUNC_INSERT, 5'd18, 32'h0000_0001, 1, 1'b1,
                               oal_pkg::ST_RANGE, 16);
        dir_table[18] = mk_row(oal_pkg::FUNC_LOCATE, 5'd0,  32'h0000_0055, 1, 1'b0,
                               oal_pkg::ST_DONE,  0);
        dir_table[19] = mk_row(oal_pkg::FUNC_LOCATE, 5'd0,  32'hFFFF_FFFF, 1, 1'b0,
                               oal_pkg::ST_DONE,  0);
        dir_table[20] = mk_row(oal_pkg::FUNC_DELETE, 5'd16, 32'h0000_0000, 1, 1'b0,
                               oal_pkg::ST_DONE,  0);
        dir_table[21] = mk_row(oal_pkg::FUNC_DELETE, 5'd17, 32'h0000_0000, 1, 1'b1,
                               oal_pkg::ST_RANGE, 15);
        dir_table[22] = mk_row(oal_pkg::FUNC_LOCATE, 5'd0,  32'h0000_1234, 1, 1'b1,
                               oal_pkg::ST_DONE,  15);
        dir_table[23] = mk_row(oal_pkg::FUNC_DELETE, 5'd1,  32'h0000_0000, 15, 1'b0,
                               oal_pkg::ST_DONE, 0);
        dir_table[24] = mk_row(oal_pkg::FUNC_LOCATE, 5'd0,  32'h0000_0055, 1, 1'b1,
                               oal_pkg::ST_DONE,  0);
    end

    // Build a random word, mostly well formed for the current list
    function automatic t_req_word random_word();
        t_req_word w;
        int roll;
        int cnt;
        w = '0;
        cnt = list_count;
        if (mood_left == 0) begin
            mood      = $urandom_range(MOOD_MIX, MOOD_GROW);
            mood_left = $urandom_range(8, 40);
        end
        mood_left--;

        // Pick the operation
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            w.func = FUNC_SPARE;
        end else if (roll < 24) begin
            w.func = oal_pkg::FUNC_LOCATE;
        end else begin
            roll = $urandom_range(0, 99);
            unique case (mood)
                MOOD_GROW:   w.func = (roll < 80) ? oal_pkg::FUNC_INSERT : oal_pkg::FUNC_DELETE;
                MOOD_SHRINK: w.func = (roll < 80) ? oal_pkg::FUNC_DELETE : oal_pkg::FUNC_INSERT;
                default:     w.func = (roll < 50) ? oal_pkg::FUNC_INSERT : oal_pkg::FUNC_DELETE;
            endcase
        end

        // Pick a position, in range most of the time
        if ($urandom_range(0, 99) < 12) begin
            w.pos = oal_pkg::CNT_W'($urandom_range(0, 31));
        end else if (w.func == oal_pkg::FUNC_INSERT) begin
            w.pos = oal_pkg::CNT_W'($urandom_range(1, cnt + 1));
        end else if (w.func == oal_pkg::FUNC_DELETE && cnt > 0) begin
            w.pos = oal_pkg::CNT_W'($urandom_range(1, cnt));
        end else begin
            w.pos = oal_pkg::CNT_W'($urandom_range(0, 31));
        end

        // Pick a value: held entries for locate, corners, a small set for duplicates
        roll = $urandom_range(0, 99);
        if (w.func == oal_pkg::FUNC_LOCATE && cnt > 0 && roll < 65) begin
            w.val = list_entries[$urandom_range(0, cnt - 1)];
        end else if (roll < 4) begin
            w.val = 32'h0000_0000;
        end else if (roll < 8) begin
            w.val = 32'hFFFF_FFFF;
        end else if (roll < 12) begin
            w.val = 32'h8000_0000;
        end else if (roll < 16) begin
            w.val = 32'h7FFF_FFFF;
        end else if (roll < 40) begin
            w.val = oal_pkg::DATA_W'($urandom_range(0, 7));
        end else begin
            w.val = $urandom;
        end
        return w;
    endfunction

    // Accept request words into the shadow list and present the next one
    always @(posedge i_clk) begin : drive_requests
        t_list_result pred;
        logic         more;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                pred = list_apply(cur_word.func, cur_word.pos, cur_word.val);
                awaited_results.push_back(cur_word.typed ? cur_word.want : pred);
                words_accepted <= words_accepted + 1;
            end
            more = (dir_idx < DIR_ROWS) || (rand_issued < RAND_WORDS);
            // Hold a stalled word; otherwise pick the next one or idle
            if (!i_valid || !o_stall) begin
                if (!more) begin
                    i_valid       <= 1'b0;
                    requests_done <= 1'b1;
                end else if (!calm_window && $urandom_range(0, 99) < IDLE_PCT) begin
                    i_valid <= 1'b0;
                end else begin
                    if (dir_idx < DIR_ROWS) begin
                        cur_word = dir_table[dir_idx].word;
                        dir_rep++;
                        if (dir_rep == int'(dir_table[dir_idx].rep)) begin
                            dir_idx++;
                            dir_rep = 0;
                        end
                    end else begin
                        cur_word = random_word();
                        rand_issued++;
                    end
                    i_valid      <= 1'b1;
                    i_func       <= cur_word.func;
                    i_position   <= cur_word.pos;
                    i_item_value <= cur_word.val;
                end
            end
        end
    end

    // Stall the result side at random outside the calm window
    always @(posedge i_clk) begin
        if (!i_rst_n || calm_window) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic flag_mismatch(string what, logic [oal_pkg::DATA_W-1:0] got,
                                 logic [oal_pkg::DATA_W-1:0] want);
        $display("%0t result %0d: %s got 0x%0h want 0x%0h", $realtime, results_seen, what,
                 got, want);
        error_count++;
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch("result with nothing awaited", '0, '0);
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    flag_mismatch("status", oal_pkg::DATA_W'(o_status),
                                  oal_pkg::DATA_W'(want.status));
                end
                if (o_found_position !== want.found) begin
                    flag_mismatch("found_position", oal_pkg::DATA_W'(o_found_position),
                                  oal_pkg::DATA_W'(want.found));
                end
                if (o_removed_value !== want.removed) begin
                    flag_mismatch("removed_value", o_removed_value, want.removed);
                end
                if (o_list_length !== want.length) begin
                    flag_mismatch("list_length", oal_pkg::DATA_W'(o_list_length),
                                  oal_pkg::DATA_W'(want.length));
                end
            end
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Give up once the cycle limit is reached
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("ordered_array_list verification failed");
        $finish;
    end

    // Release reset, drain the results, then report
    initial begin : run_control
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(requests_done && awaited_results.size() == 0)) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ordered_array_list verification clean");
        end else begin
            $display("ordered_array_list verification failed");
        end
        $finish;
    end

endmodule
